[rtl/lvsel_pkg.sv]
// ----------------------------------------------------------------------------
// lvsel_pkg
// shared widths, operation codes and register map of the level selector
// ----------------------------------------------------------------------------
package lvsel_pkg;

  localparam int BYTE_W     = 48;
  localparam int MILLIS_W   = 32;
  localparam int CHUNK_B_W  = 32;
  localparam int CHUNK_M_W  = 24;
  localparam int RATE_W     = 32;
  localparam int FRAC_W     = 9;
  localparam int COUNT_W    = 4;
  localparam int SLOT_W     = 3;
  localparam int INDEX_W    = 3;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // byte_total * 1000 fits in 58 bits
  localparam int DIVIDEND_W = 58;
  localparam int Q8_SHIFT   = 8;

  localparam logic [9:0]        MS_PER_SECOND = 10'd1000;
  localparam logic [FRAC_W-1:0] FRACTION_ONE  = 9'd256;
  localparam logic [FRAC_W-1:0] FRACTION_RST  = 9'd205;
  localparam logic [COUNT_W-1:0] COUNT_RST    = 4'd8;

  typedef enum logic [1:0] {
    OP_CHUNK   = 2'd0,
    OP_QUERY   = 2'd1,
    OP_RESTART = 2'd2,
    OP_LOAD    = 2'd3
  } op_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_FRACTION = 1'b0,
    REG_COUNT    = 1'b1
  } reg_idx_t;

endpackage

[rtl/throughput_rate_level_selector.sv]
// ----------------------------------------------------------------------------
// throughput_rate_level_selector
// picks a rate level from accumulated chunk throughput
// sequence: chunk report, restart and load go straight to the done state for
//   their acknowledgement; a query runs the divider, a scaling step, then a
//   table read and compare per entry examined (at most LEVELS), or entry 0 alone
//   with no elapsed time; one transaction at a time, the next taken the cycle
//   after the result is registered; the serial divider and the per-entry
//   table scan set the query time
// reset: totals cleared, fraction 205, level count 8, table contents undefined
// ----------------------------------------------------------------------------
module throughput_rate_level_selector
  import lvsel_pkg::*;
#(
  parameter int LEVELS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  // input transactions
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             op,
  input  logic [CHUNK_B_W-1:0]   chunk_bytes,
  input  logic [CHUNK_M_W-1:0]   chunk_millis,
  input  logic [SLOT_W-1:0]      level_slot,
  input  logic [RATE_W-1:0]      level_value,
  // result transactions
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [INDEX_W-1:0]     chosen_index,
  output logic [RATE_W-1:0]      chosen_rate,
  output logic                   is_answer
);

  localparam int IDX_W = $clog2(LEVELS);

  // one-hot sequencer
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DIV      = 6'b000010,
    ST_SCALE    = 6'b000100,
    ST_SCAN_RD  = 6'b001000,
    ST_SCAN_CMP = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [FRAC_W-1:0]  fraction_q8;
  logic [COUNT_W-1:0] level_count;
  logic               cfg_write;

  // running totals
  logic [BYTE_W-1:0]   byte_total;
  logic [MILLIS_W-1:0] millis_total;
  logic [BYTE_W:0]     byte_sum;
  logic [MILLIS_W:0]   millis_sum;

  // query datapath
  logic                        accept;
  op_t                         op_in;
  logic                        div_start;
  logic                        div_done;
  logic [DIVIDEND_W-1:0]       dividend;
  logic [DIVIDEND_W-1:0]       quotient;
  logic [FRAC_W-1:0]           frac_eff;
  logic [DIVIDEND_W+FRAC_W-1:0] scaled;
  logic [DIVIDEND_W-1:0]       est;
  logic                        below;

  // table scan
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  scan_last;
  logic [IDX_W-1:0]  pick;
  logic [RATE_W-1:0] pick_rate;
  logic              answer;
  logic              tbl_wr;
  logic [RATE_W-1:0] tbl_rd_data;

  // ---------------------------------------------------------------------------
  // configuration port: always ready, register picked by paddr[2]
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_q8 <= FRACTION_RST;
      level_count <= COUNT_RST;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_FRACTION: fraction_q8 <= pwdata[FRAC_W-1:0];
        REG_COUNT:    level_count <= pwdata[COUNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_FRACTION: prdata = {{(APB_DATA_W-FRAC_W){1'b0}}, fraction_q8};
      REG_COUNT:    prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, level_count};
    endcase
  end

  // ---------------------------------------------------------------------------
  // input side: one transaction at a time, taken only from idle
  // ---------------------------------------------------------------------------
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign op_in    = op_t'(op);

  // saturating totals
  assign byte_sum   = {1'b0, byte_total} + (BYTE_W+1)'(chunk_bytes);
  assign millis_sum = {1'b0, millis_total} + (MILLIS_W+1)'(chunk_millis);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total   <= '0;
      millis_total <= '0;
    end else if (accept) begin
      if (op_in == OP_CHUNK) begin
        byte_total   <= byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
        millis_total <= millis_sum[MILLIS_W] ? '1 : millis_sum[MILLIS_W-1:0];
      end else if (op_in == OP_RESTART) begin
        byte_total   <= '0;
        millis_total <= '0;
      end
    end
  end

  // loads beyond the table depth are dropped
  assign tbl_wr = accept && (op_in == OP_LOAD) && (32'(level_slot) < LEVELS);

  // ---------------------------------------------------------------------------
  // measured rate: byte_total * 1000 / millis_total on the serial divider
  // ---------------------------------------------------------------------------
  assign dividend  = DIVIDEND_W'(byte_total) * DIVIDEND_W'(MS_PER_SECOND);
  assign div_start = accept && (op_in == OP_QUERY) && (millis_total != '0);

  lvsel_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (millis_total),
    .done     (div_done),
    .quotient (quotient)
  );

  // usable share, anything above one counts as one; low 8 bits dropped
  assign frac_eff = (fraction_q8 > FRACTION_ONE) ? FRACTION_ONE : fraction_q8;
  assign scaled   = {{FRAC_W{1'b0}}, quotient} * {{DIVIDEND_W{1'b0}}, frac_eff};

  always_ff @(posedge clk) begin
    if (state == ST_SCALE) begin
      est <= scaled[DIVIDEND_W+Q8_SHIFT-1:Q8_SHIFT];
    end
  end

  // ---------------------------------------------------------------------------
  // level table and ascending scan
  // ---------------------------------------------------------------------------
  lvsel_table #(
    .LEVELS (LEVELS)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (IDX_W'(level_slot)),
    .wr_data (level_value),
    .rd_addr (scan_idx),
    .rd_data (tbl_rd_data)
  );

  assign below = {{(DIVIDEND_W-RATE_W){1'b0}}, tbl_rd_data} < est;

  // last entry to look at; no elapsed time or a count of zero looks only at entry 0
  always_ff @(posedge clk) begin
    if (accept && (op_in == OP_QUERY)) begin
      if ((millis_total == '0) || (level_count == '0)) begin
        scan_last <= '0;
      end else if (32'(level_count) >= LEVELS) begin
        scan_last <= IDX_W'(LEVELS - 1);
      end else begin
        scan_last <= IDX_W'(level_count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_idx  <= '0;
      pick      <= '0;
      pick_rate <= '0;
      answer    <= (op_in == OP_QUERY);
    end else if (state == ST_SCAN_CMP) begin
      // entry 0 is the floor; later entries only while still below
      if (scan_idx == '0 || below) begin
        pick      <= scan_idx;
        pick_rate <= tbl_rd_data;
      end
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op_in != OP_QUERY) begin
            state_next = ST_DONE;
          end else if (millis_total == '0) begin
            state_next = ST_SCAN_RD;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE:   state_next = ST_SCAN_RD;
      ST_SCAN_RD: state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (!below || scan_idx == scan_last) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // output register: loaded from the done state once the slot is free
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      chosen_index <= INDEX_W'(pick);
      chosen_rate  <= pick_rate;
      is_answer    <= answer;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_CMP) |-> (scan_idx <= scan_last))
    else $error("table scan ran past the last entry");

  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_answer) |-> (chosen_index == '0 && chosen_rate == '0))
    else $error("acknowledgement carries a nonzero level");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted transaction left the sequencer idle");

endmodule

[rtl/lvsel_div.sv]
// ----------------------------------------------------------------------------
// lvsel_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lvsel_div
  import lvsel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [MILLIS_W-1:0]   divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [MILLIS_W-1:0]   rem;
  logic [MILLIS_W-1:0]   dvsr;
  logic [DIVIDEND_W-1:0] quo;
  logic [MILLIS_W:0]     shifted;
  logic [MILLIS_W:0]     diff;
  logic                  fits;

  // quo holds the remaining dividend bits on top, quotient bits shift in below
  assign shifted = {rem, quo[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvsr};
  assign fits    = shifted >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[MILLIS_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= shifted[MILLIS_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

[rtl/lvsel_table.sv]
// ----------------------------------------------------------------------------
// lvsel_table
// level rate table, one write port and one registered read port
// ----------------------------------------------------------------------------
module lvsel_table
  import lvsel_pkg::*;
#(
  parameter int LEVELS = 8
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(LEVELS)-1:0] wr_addr,
  input  logic [RATE_W-1:0]         wr_data,
  input  logic [$clog2(LEVELS)-1:0] rd_addr,
  output logic [RATE_W-1:0]         rd_data
);

  logic [RATE_W-1:0] mem [LEVELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the throughput level selector: drives chunk
// reports, queries, restarts and table loads through the valid/stall
// channel, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module tb_top;
  import lvsel_pkg::*;

  localparam int  LEVELS      = 8;
  localparam time CLK_PERIOD  = 20ns;
  localparam int  RESET_TICKS = 7;
  localparam int  SETTLE_TICKS = 8;
  localparam int  END_TICKS    = 100;
  // some 1300 transactions, each well inside the limit even when stalled
  localparam int  CYCLE_LIMIT  = 1_000_000;

  localparam logic [BYTE_W-1:0]   BYTES_SAT  = '1;
  localparam logic [MILLIS_W-1:0] MILLIS_SAT = '1;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [RATE_W-1:0]  rate;
    logic               answer;
  } level_answer_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // configuration port
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // input channel
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  op_t                  op           = OP_CHUNK;
  logic [CHUNK_B_W-1:0] chunk_bytes  = '0;
  logic [CHUNK_M_W-1:0] chunk_millis = '0;
  logic [SLOT_W-1:0]    level_slot   = '0;
  logic [RATE_W-1:0]    level_value  = '0;

  // result channel
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [INDEX_W-1:0] chosen_index;
  logic [RATE_W-1:0]  chosen_rate;
  logic               is_answer;

  throughput_rate_level_selector #(
    .LEVELS(LEVELS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .chunk_bytes  (chunk_bytes),
    .chunk_millis (chunk_millis),
    .level_slot   (level_slot),
    .level_value  (level_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen_index (chosen_index),
    .chosen_rate  (chosen_rate),
    .is_answer    (is_answer)
  );

  // --------------------------------------------------------------------------
  // predictor state, mirrors the block from reset
  // --------------------------------------------------------------------------
  logic [FRAC_W-1:0]   frac_reg   = FRACTION_RST;
  logic [COUNT_W-1:0]  count_reg  = COUNT_RST;
  logic [BYTE_W-1:0]   acc_bytes  = '0;
  logic [MILLIS_W-1:0] acc_millis = '0;
  logic [RATE_W-1:0]   rate_table [LEVELS];

  level_answer_t pending_answers[$];
  level_answer_t want;

  int errors      = 0;
  int item_count  = 0;
  int cycle_count = 0;
  int idle_pct    = 0;   // chance in 100 that the sender skips a cycle
  int stall_pct   = 0;   // chance in 100 that the receiver stalls a cycle

  // usable rate: floor(bytes * 1000 / millis), then scaled by the q8 share
  function automatic logic [63:0] usable_rate();
    logic [63:0] measured;
    logic [63:0] share;
    measured = (64'(acc_bytes) * 64'(MS_PER_SECOND)) / 64'(acc_millis);
    share = (frac_reg > FRACTION_ONE) ? 64'(FRACTION_ONE) : 64'(frac_reg);
    return (measured >> Q8_SHIFT) * share + (((measured & 64'hFF) * share) >> Q8_SHIFT);
  endfunction

  // ascending scan: last entry below the estimate, stop at first that is not
  function automatic logic [INDEX_W-1:0] select_level();
    logic [63:0]        est;
    logic [INDEX_W-1:0] pick;
    int                 n;
    bit                 stopped;
    pick    = '0;
    stopped = 1'b0;
    if (acc_millis == '0) return '0;
    // a count of zero acts as one, anything above the table size as the size
    n   = (count_reg == '0) ? 1 : ((int'(count_reg) > LEVELS) ? LEVELS : int'(count_reg));
    est = usable_rate();
    for (int i = 0; i < n; i++) begin
      if (!stopped) begin
        if (64'(rate_table[i]) < est) pick = INDEX_W'(i);
        else stopped = 1'b1;
      end
    end
    return pick;
  endfunction

  // apply one accepted transaction to the predictor, return its result
  function automatic level_answer_t advance_selector(input op_t o,
                                                     input logic [CHUNK_B_W-1:0] b,
                                                     input logic [CHUNK_M_W-1:0] m,
                                                     input logic [SLOT_W-1:0] s,
                                                     input logic [RATE_W-1:0] v);
    level_answer_t      res;
    logic [BYTE_W:0]    bsum;
    logic [MILLIS_W:0]  msum;
    logic [INDEX_W-1:0] idx;
    res = '0;
    case (o)
      OP_CHUNK: begin
        // both totals saturate instead of wrapping
        bsum = {1'b0, acc_bytes} + (BYTE_W + 1)'(b);
        msum = {1'b0, acc_millis} + (MILLIS_W + 1)'(m);
        acc_bytes  = bsum[BYTE_W]   ? BYTES_SAT  : bsum[BYTE_W-1:0];
        acc_millis = msum[MILLIS_W] ? MILLIS_SAT : msum[MILLIS_W-1:0];
      end
      OP_QUERY: begin
        idx        = select_level();
        res.index  = idx;
        res.rate   = rate_table[idx];
        res.answer = 1'b1;
      end
      OP_RESTART: begin
        acc_bytes  = '0;
        acc_millis = '0;
      end
      default: begin
        // every 3-bit slot is inside an 8-entry table
        if (int'(s) < LEVELS) rate_table[s] = v;
      end
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // driving
  // --------------------------------------------------------------------------

  // one input transaction; idles first at the current sender rate
  task automatic send_item(input op_t o,
                           input logic [CHUNK_B_W-1:0] b = '0,
                           input logic [CHUNK_M_W-1:0] m = '0,
                           input logic [SLOT_W-1:0] s = '0,
                           input logic [RATE_W-1:0] v = '0);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    chunk_bytes  <= b;
    chunk_millis <= m;
    level_slot   <= s;
    level_value  <= v;
    // in_stall read right after the edge is the value the block used there
    do @(posedge clk); while (in_stall);
    pending_answers.push_back(advance_selector(o, b, m, s, v));
    item_count++;
  endtask

  // stop sending and let every expected result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_t r, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (r == REG_FRACTION) frac_reg = value[FRAC_W-1:0];
    else count_reg = value[COUNT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // registers only change while nothing is in flight
  task automatic set_config(input int frac, input int count);
    wait_idle();
    write_reg(REG_FRACTION, APB_DATA_W'(frac));
    write_reg(REG_COUNT, APB_DATA_W'(count));
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 57; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 57; end
      default: begin idle_pct = 29; stall_pct = 29; end
    endcase
  endtask

  // fill every slot, mostly ascending with some equal neighbors,
  // now and then a scrambled table
  task automatic load_level_table();
    logic [63:0] level;
    bit          scrambled;
    scrambled = ($urandom_range(5) == 0);
    level     = 64'($urandom_range(20000));
    for (int i = 0; i < LEVELS; i++) begin
      if (scrambled) level = 64'($urandom);
      else if (i != 0) level = level + 64'($urandom_range(400000));
      if (level > 64'hFFFF_FFFF) level = 64'hFFFF_FFFF;
      send_item(OP_LOAD, '0, '0, SLOT_W'(i), level[RATE_W-1:0]);
    end
  endtask

  // a measured download aimed near one table entry, then a query
  task automatic run_measured_query();
    logic [63:0] target;
    logic [63:0] share;
    logic [63:0] want_bytes;
    int          millis;
    int          chunks;
    share  = (frac_reg > FRACTION_ONE) ? 64'(FRACTION_ONE) : 64'(frac_reg);
    if (share == 0) share = 64'd1;
    target = (64'(rate_table[$urandom_range(LEVELS - 1)]) << Q8_SHIFT) / share;
    // hit an entry exactly, just above, just below, or somewhere near
    case ($urandom_range(3))
      0: ;
      1: target = target + 64'd1;
      2: if (target != 0) target = target - 64'd1;
      default: target = target + 64'($urandom_range(200000));
    endcase
    if ($urandom_range(9) < 7) send_item(OP_RESTART);
    chunks = $urandom_range(1, 3);
    repeat (chunks) begin
      // a whole second keeps the estimate exact
      millis     = ($urandom_range(2) == 0) ? 1000 : $urandom_range(1, 4000);
      want_bytes = target * 64'(millis) / 64'(MS_PER_SECOND);
      if (want_bytes > 64'hFFFF_FFFF) want_bytes = 64'hFFFF_FFFF;
      send_item(OP_CHUNK, want_bytes[CHUNK_B_W-1:0], CHUNK_M_W'(millis));
    end
    send_item(OP_QUERY);
  endtask

  // unshaped transactions with every field at full width
  task automatic send_noise();
    send_item(op_t'($urandom_range(3)), $urandom, CHUNK_M_W'($urandom),
              SLOT_W'($urandom), $urandom);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset register values, zero elapsed time, a plain measurement
  task automatic test_reset_defaults();
    logic [RATE_W-1:0] ladder [LEVELS];
    ladder = '{32'd1000, 32'd5000, 32'd20000, 32'd80000,
               32'd300000, 32'd1000000, 32'd4000000, 32'd16000000};
    set_idling(0);
    // the table has no defined contents until every slot is loaded
    for (int i = 0; i < LEVELS; i++) send_item(OP_LOAD, '0, '0, SLOT_W'(i), ladder[i]);
    send_item(OP_QUERY);
    // 100000 B/s at the reset share of 205/256 lands just above 80000
    send_item(OP_CHUNK, 32'd100000, 24'd1000);
    send_item(OP_QUERY);
    send_item(OP_RESTART);
    send_item(OP_QUERY);
  endtask

  // field extremes, share of zero and above one, counts out of range
  task automatic test_field_extremes();
    set_idling(3);
    send_item(OP_CHUNK, '1, '1);
    send_item(OP_QUERY);
    send_item(OP_CHUNK, '0, '0);
    send_item(OP_QUERY);
    send_item(OP_LOAD, '0, '0, SLOT_W'(LEVELS - 1), '1);
    send_item(OP_LOAD, '0, '0, '0, '0);
    set_config(0, LEVELS);
    send_item(OP_QUERY);
    set_config(511, 0);
    send_item(OP_QUERY);
    set_config(int'(FRACTION_ONE), 15);
    send_item(OP_QUERY);
    send_item(OP_RESTART);
    send_item(OP_QUERY);
  endtask

  // millisecond total pinned at its maximum
  task automatic test_total_saturation();
    logic [RATE_W-1:0] ladder [LEVELS];
    ladder = '{32'd100000, 32'd200000, 32'd250000, 32'd300000,
               32'd1000000, 32'd50000000, 32'd60000000, 32'd70000000};
    set_idling(0);
    set_config(int'(FRACTION_ONE), LEVELS);
    for (int i = 0; i < LEVELS; i++) send_item(OP_LOAD, '0, '0, SLOT_W'(i), ladder[i]);
    send_item(OP_RESTART);
    // 257 full-scale chunks run the millisecond total past its limit
    repeat (257) send_item(OP_CHUNK, '1, '1);
    send_item(OP_QUERY);
    send_item(OP_CHUNK, '1, '1);
    send_item(OP_QUERY);
  endtask

  // random traffic over several register settings and idling modes
  task automatic test_random_traffic();
    int share_set [8] = '{256, 205, 511, 128, 1, 300, 64, 256};
    int count_set [8] = '{8, 1, 15, 0, 5, 8, 3, 8};
    int phase_end;
    int pick;
    for (int p = 0; p < 8; p++) begin
      set_config(share_set[p], count_set[p]);
      set_idling(p % 4);
      load_level_table();
      phase_end = item_count + 100;
      while (item_count < phase_end) begin
        pick = $urandom_range(19);
        if (pick < 15) run_measured_query();
        else if (pick < 18) repeat ($urandom_range(1, 3)) send_noise();
        else if (pick == 18) load_level_table();
        else wait_idle();   // sender holds off until all results are back
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // result checking, one transaction per accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t unexpected result: index %0d rate %0h answer %0b",
                 $time, chosen_index, chosen_rate, is_answer);
      end else begin
        want = pending_answers.pop_front();
        if (chosen_index !== want.index) begin
          errors++;
          $display("%0t chosen_index expected %0d actual %0d", $time, want.index, chosen_index);
        end
        if (chosen_rate !== want.rate) begin
          errors++;
          $display("%0t chosen_rate expected %0h actual %0h", $time, want.rate, chosen_rate);
        end
        if (is_answer !== want.answer) begin
          errors++;
          $display("%0t is_answer expected %0b actual %0b", $time, want.answer, is_answer);
        end
      end
    end
  end

  // receiver stalls at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sequence of tests
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_total_saturation();
    test_random_traffic();
    wait_idle();
    repeat (END_TICKS) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lvsel_pkg.sv
rtl/lvsel_div.sv
rtl/lvsel_table.sv
rtl/throughput_rate_level_selector.sv
sim/tb_top.sv
